// ===== hdl/gabr_pkg.sv =====
// gabr_pkg: shared types, codes and constants of the gemm row engine
// no dependencies; used by every other file of the block but gabr_ram
`default_nettype none

package gabr_pkg;

  localparam int DEF_MAX_DIM = 16;
  localparam int DIM_LIMIT   = 16;

  localparam int KIND_W    = 2;
  localparam int IDX_W     = 4;
  localparam int DIM_W     = 5;
  localparam int VAL_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;

  localparam int MUL_W  = VAL_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 2 * VAL_W + 4;
  localparam int PART_W = (ACC_W - FRAC_W) / 2;
  localparam int TOT_W  = 86;

  localparam logic [DIM_W-1:0] RESET_DIM          = DIM_W'(16);
  localparam logic signed [VAL_W-1:0] RESET_ALPHA = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] RESET_BETA  = 32'sh0000_0000;
  localparam logic signed [VAL_W-1:0] SAT_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] SAT_MIN     = 32'sh8000_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_LOAD_C = 2'd2,
    KIND_ROW    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_M  = 3'd0,
    REG_INNER_N = 3'd1,
    REG_COLS_P  = 3'd2,
    REG_ALPHA   = 3'd3,
    REG_BETA    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_MAC      = 2'd0,
    OP_ALPHA_LO = 2'd1,
    OP_ALPHA_HI = 2'd2,
    OP_BETA_C   = 2'd3
  } mul_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ALPHA_LO,
    ST_ALPHA_HI,
    ST_BETA_C,
    ST_SETTLE,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]        m_last;
    logic [IDX_W-1:0]        n_last;
    logic [IDX_W-1:0]        p_last;
    logic signed [VAL_W-1:0] alpha;
    logic signed [VAL_W-1:0] beta;
  } cfg_t;

  typedef struct packed {
    logic    clear;
    logic    mul_en;
    mul_op_t mul_op;
  } dp_ctl_t;

  typedef struct packed {
    logic busy;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/gabr_if.sv =====
// gabr_in_if, gabr_out_if, gabr_cfg_if: valid/ready channels of the row engine
// depends on gabr_pkg for payload widths
`default_nettype none

interface gabr_in_if;
  logic                            valid;
  logic                            ready;
  logic [gabr_pkg::KIND_W-1:0]     kind;
  logic [gabr_pkg::IDX_W-1:0]      row_index;
  logic [gabr_pkg::IDX_W-1:0]      col_index;
  logic signed [gabr_pkg::VAL_W-1:0] elem_value;

  modport source (output valid, kind, row_index, col_index, elem_value, input ready);
  modport sink (input valid, kind, row_index, col_index, elem_value, output ready);
endinterface

interface gabr_out_if;
  logic                            valid;
  logic                            ready;
  logic [gabr_pkg::IDX_W-1:0]      out_row;
  logic [gabr_pkg::IDX_W-1:0]      out_col;
  logic signed [gabr_pkg::VAL_W-1:0] out_value;
  logic                            last_of_row;

  modport source (output valid, out_row, out_col, out_value, last_of_row, input ready);
  modport sink (input valid, out_row, out_col, out_value, last_of_row, output ready);
endinterface

interface gabr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gabr_pkg::CFG_IDX_W-1:0] index;
  logic [gabr_pkg::VAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/gemm_alpha_beta_row_engine.sv =====
// gemm_alpha_beta_row_engine: C = alpha*A*B + beta*C, one result row per request
// depends on gabr_pkg, gabr_if, gabr_ram, gabr_cfg, gabr_dp, gabr_seq
//
//   channel  dir  word
//   item     in   kind, row_index, col_index, elem_value
//   result   out  out_row, out_col, out_value, last_of_row (one word per column)
//   cfg      in   index, data (register write)
//
// a row request holds the input while it works, per column, through n products
// on the one shared multiplier, a drain, three scaling products, a settle wait
// and the emit of the result word
// items are taken only while the sequencer is idle; a finished word may
// wait in the result register while the next item is taken, and a word still
// held there by the consumer stalls the emit state of the next column
// rst clears control state; the a, b and c stores are not cleared
`default_nettype none

module gemm_alpha_beta_row_engine #(
  parameter int MAX_DIM = gabr_pkg::DEF_MAX_DIM
) (
  input wire logic   clk,
  input wire logic   rst,
  gabr_in_if.sink    item,
  gabr_out_if.source result,
  gabr_cfg_if.sink   cfg
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  gabr_pkg::cfg_t    cfg_eff;
  gabr_pkg::dp_ctl_t ctl;
  gabr_pkg::dp_sts_t sts;

  logic                              load_ok;
  logic                              we_a;
  logic                              we_b;
  logic                              we_c;
  logic [AW-1:0]                     waddr;
  logic                              ab_en;
  logic                              c_en;
  logic [AW-1:0]                     a_addr;
  logic [AW-1:0]                     b_addr;
  logic [AW-1:0]                     c_addr;
  logic [gabr_pkg::VAL_W-1:0]        a_q;
  logic [gabr_pkg::VAL_W-1:0]        b_q;
  logic [gabr_pkg::VAL_W-1:0]        c_q;
  logic signed [gabr_pkg::VAL_W-1:0] value;

  // loads beyond the store are dropped
  assign load_ok = item.valid && item.ready && item.kind != gabr_pkg::KIND_ROW
                   && int'(item.row_index) < MAX_DIM && int'(item.col_index) < MAX_DIM;
  assign we_a  = load_ok && item.kind == gabr_pkg::KIND_LOAD_A;
  assign we_b  = load_ok && item.kind == gabr_pkg::KIND_LOAD_B;
  assign we_c  = load_ok && item.kind == gabr_pkg::KIND_LOAD_C;
  assign waddr = AW'(item.row_index) * AW'(MAX_DIM) + AW'(item.col_index);

  gabr_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_eff (cfg_eff)
  );

  gabr_ram #(.WIDTH(gabr_pkg::VAL_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (item.elem_value),
    .re    (ab_en),
    .raddr (a_addr),
    .rdata (a_q)
  );

  gabr_ram #(.WIDTH(gabr_pkg::VAL_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (item.elem_value),
    .re    (ab_en),
    .raddr (b_addr),
    .rdata (b_q)
  );

  gabr_ram #(.WIDTH(gabr_pkg::VAL_W), .DEPTH(DEPTH)) u_store_c (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr),
    .wdata (item.elem_value),
    .re    (c_en),
    .raddr (c_addr),
    .rdata (c_q)
  );

  gabr_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .a_q   ($signed(a_q)),
    .b_q   ($signed(b_q)),
    .c_q   ($signed(c_q)),
    .alpha (cfg_eff.alpha),
    .beta  (cfg_eff.beta),
    .sts   (sts),
    .value (value)
  );

  gabr_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_eff   (cfg_eff),
    .in_valid  (item.valid),
    .in_kind   (item.kind),
    .in_row    (item.row_index),
    .in_ready  (item.ready),
    .ab_en     (ab_en),
    .c_en      (c_en),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .c_addr    (c_addr),
    .ctl       (ctl),
    .sts       (sts),
    .value     (value),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_row   (result.out_row),
    .out_col   (result.out_col),
    .out_value (result.out_value),
    .out_last  (result.last_of_row)
  );

endmodule

`default_nettype wire

// ===== hdl/gabr_ram.sv =====
// gabr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module gabr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gabr_cfg.sv =====
// gabr_cfg: configuration registers and effective matrix sizes
// depends on gabr_pkg and gabr_cfg_if
`default_nettype none

module gabr_cfg #(
  parameter int MAX_DIM = gabr_pkg::DEF_MAX_DIM
) (
  input  wire logic      clk,
  input  wire logic      rst,
  gabr_cfg_if.sink       cfg,
  output gabr_pkg::cfg_t cfg_eff
);

  localparam int DIM_CAP = (MAX_DIM < gabr_pkg::DIM_LIMIT) ? MAX_DIM : gabr_pkg::DIM_LIMIT;

  logic [gabr_pkg::DIM_W-1:0]        rows_m;
  logic [gabr_pkg::DIM_W-1:0]        inner_n;
  logic [gabr_pkg::DIM_W-1:0]        cols_p;
  logic signed [gabr_pkg::VAL_W-1:0] alpha_gain;
  logic signed [gabr_pkg::VAL_W-1:0] beta_gain;

  function automatic logic [gabr_pkg::IDX_W-1:0] last_of(input logic [gabr_pkg::DIM_W-1:0] v);
    logic [gabr_pkg::DIM_W-1:0] e;
    if (v == '0) begin
      e = gabr_pkg::DIM_W'(1);
    end else if (v > gabr_pkg::DIM_W'(DIM_CAP)) begin
      e = gabr_pkg::DIM_W'(DIM_CAP);
    end else begin
      e = v;
    end
    return gabr_pkg::IDX_W'(e - gabr_pkg::DIM_W'(1));
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m     <= gabr_pkg::RESET_DIM;
      inner_n    <= gabr_pkg::RESET_DIM;
      cols_p     <= gabr_pkg::RESET_DIM;
      alpha_gain <= gabr_pkg::RESET_ALPHA;
      beta_gain  <= gabr_pkg::RESET_BETA;
    end else if (cfg.valid) begin
      case (cfg.index)
        gabr_pkg::REG_ROWS_M:  rows_m     <= cfg.data[gabr_pkg::DIM_W-1:0];
        gabr_pkg::REG_INNER_N: inner_n    <= cfg.data[gabr_pkg::DIM_W-1:0];
        gabr_pkg::REG_COLS_P:  cols_p     <= cfg.data[gabr_pkg::DIM_W-1:0];
        gabr_pkg::REG_ALPHA:   alpha_gain <= $signed(cfg.data);
        gabr_pkg::REG_BETA:    beta_gain  <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_eff.m_last = last_of(rows_m);
    cfg_eff.n_last = last_of(inner_n);
    cfg_eff.p_last = last_of(cols_p);
    cfg_eff.alpha  = alpha_gain;
    cfg_eff.beta   = beta_gain;
  end

endmodule

`default_nettype wire

// ===== hdl/gabr_dp.sv =====
// gabr_dp: shared 33x33 multiplier, dot-product accumulator, scaling and saturation
// depends on gabr_pkg
`default_nettype none

module gabr_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire gabr_pkg::dp_ctl_t                 ctl,
  input  wire logic signed [gabr_pkg::VAL_W-1:0] a_q,
  input  wire logic signed [gabr_pkg::VAL_W-1:0] b_q,
  input  wire logic signed [gabr_pkg::VAL_W-1:0] c_q,
  input  wire logic signed [gabr_pkg::VAL_W-1:0] alpha,
  input  wire logic signed [gabr_pkg::VAL_W-1:0] beta,
  output gabr_pkg::dp_sts_t                      sts,
  output logic signed [gabr_pkg::VAL_W-1:0]      value
);

  localparam int SAT_LO = gabr_pkg::FRAC_W + gabr_pkg::VAL_W - 1;

  logic signed [gabr_pkg::MUL_W-1:0]  mx;
  logic signed [gabr_pkg::MUL_W-1:0]  my;
  logic signed [gabr_pkg::PROD_W-1:0] prod;
  gabr_pkg::mul_op_t                  prod_op;
  logic                               prod_v;
  logic signed [gabr_pkg::ACC_W-1:0]  acc;
  logic signed [gabr_pkg::TOT_W-1:0]  total;
  logic        [gabr_pkg::PART_W-1:0] p_lo;
  logic signed [gabr_pkg::PART_W-1:0] p_hi;
  logic [gabr_pkg::TOT_W-1-SAT_LO:0]  top_bits;

  // acc >>> 16 split into an unsigned low and a signed high half
  assign p_lo = acc[gabr_pkg::FRAC_W +: gabr_pkg::PART_W];
  assign p_hi = acc[gabr_pkg::FRAC_W + gabr_pkg::PART_W +: gabr_pkg::PART_W];

  always_comb begin
    case (ctl.mul_op)
      gabr_pkg::OP_MAC: begin
        mx = gabr_pkg::MUL_W'(a_q);
        my = gabr_pkg::MUL_W'(b_q);
      end
      gabr_pkg::OP_ALPHA_LO: begin
        mx = gabr_pkg::MUL_W'(alpha);
        my = $signed({{(gabr_pkg::MUL_W - gabr_pkg::PART_W){1'b0}}, p_lo});
      end
      gabr_pkg::OP_ALPHA_HI: begin
        mx = gabr_pkg::MUL_W'(alpha);
        my = gabr_pkg::MUL_W'(p_hi);
      end
      gabr_pkg::OP_BETA_C: begin
        mx = gabr_pkg::MUL_W'(beta);
        my = gabr_pkg::MUL_W'(c_q);
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod    <= mx * my;
      prod_op <= ctl.mul_op;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc   <= '0;
      total <= '0;
    end else if (prod_v) begin
      case (prod_op)
        gabr_pkg::OP_MAC:      acc   <= acc + gabr_pkg::ACC_W'(prod);
        gabr_pkg::OP_ALPHA_LO: total <= total + gabr_pkg::TOT_W'(prod);
        gabr_pkg::OP_ALPHA_HI: total <= total + (gabr_pkg::TOT_W'(prod) <<< gabr_pkg::PART_W);
        gabr_pkg::OP_BETA_C:   total <= total + gabr_pkg::TOT_W'(prod);
        default: ;
      endcase
    end
  end

  // floor shift by 16, then clamp to 32 bits
  assign top_bits = total[gabr_pkg::TOT_W-1:SAT_LO];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      value = total[SAT_LO:gabr_pkg::FRAC_W];
    end else if (total[gabr_pkg::TOT_W-1]) begin
      value = gabr_pkg::SAT_MIN;
    end else begin
      value = gabr_pkg::SAT_MAX;
    end
  end

  assign sts.busy = prod_v;

endmodule

`default_nettype wire

// ===== hdl/gabr_seq.sv =====
// gabr_seq: row sequencer, store read addressing and result word register
// depends on gabr_pkg
`default_nettype none

module gabr_seq #(
  parameter int MAX_DIM = gabr_pkg::DEF_MAX_DIM,
  localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire gabr_pkg::cfg_t                    cfg_eff,
  input  wire logic                              in_valid,
  input  wire logic [gabr_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [gabr_pkg::IDX_W-1:0]        in_row,
  output logic                                   in_ready,
  output logic                                   ab_en,
  output logic                                   c_en,
  output logic [AW-1:0]                          a_addr,
  output logic [AW-1:0]                          b_addr,
  output logic [AW-1:0]                          c_addr,
  output gabr_pkg::dp_ctl_t                      ctl,
  input  wire gabr_pkg::dp_sts_t                 sts,
  input  wire logic signed [gabr_pkg::VAL_W-1:0] value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [gabr_pkg::IDX_W-1:0]             out_row,
  output logic [gabr_pkg::IDX_W-1:0]             out_col,
  output logic signed [gabr_pkg::VAL_W-1:0]      out_value,
  output logic                                   out_last
);

  gabr_pkg::seq_state_t       state;
  gabr_pkg::seq_state_t       state_next;
  logic [gabr_pkg::IDX_W-1:0] row;
  logic [gabr_pkg::IDX_W-1:0] row_next;
  logic [gabr_pkg::IDX_W-1:0] k;
  logic [gabr_pkg::IDX_W-1:0] k_next;
  logic [gabr_pkg::IDX_W-1:0] j;
  logic [gabr_pkg::IDX_W-1:0] j_next;
  logic                       rd_v;
  logic                       rd_v_next;
  logic                       load_out;
  logic                       out_free;

  function automatic logic [AW-1:0] addr_of(input logic [gabr_pkg::IDX_W-1:0] r,
                                            input logic [gabr_pkg::IDX_W-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  assign a_addr   = addr_of(row, k);
  assign b_addr   = addr_of(k, j);
  assign c_addr   = addr_of(row, j);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gabr_pkg::ST_IDLE;
      rd_v  <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= rd_v_next;
    end
  end

  always_ff @(posedge clk) begin
    row <= row_next;
    k   <= k_next;
    j   <= j_next;
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    k_next     = k;
    j_next     = j;
    rd_v_next  = 1'b0;
    in_ready   = 1'b0;
    ab_en      = 1'b0;
    c_en       = 1'b0;
    load_out   = 1'b0;
    ctl.clear  = 1'b0;
    ctl.mul_en = rd_v;
    ctl.mul_op = gabr_pkg::OP_MAC;
    case (state)
      gabr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_kind == gabr_pkg::KIND_ROW && in_row <= cfg_eff.m_last) begin
          row_next   = in_row;
          k_next     = '0;
          j_next     = '0;
          state_next = gabr_pkg::ST_MAC;
        end
      end
      gabr_pkg::ST_MAC: begin
        ab_en     = 1'b1;
        rd_v_next = 1'b1;
        if (k == '0) begin
          c_en      = 1'b1;
          ctl.clear = 1'b1;
        end
        if (k == cfg_eff.n_last) begin
          k_next     = '0;
          state_next = gabr_pkg::ST_DRAIN;
        end else begin
          k_next = k + gabr_pkg::IDX_W'(1);
        end
      end
      gabr_pkg::ST_DRAIN: begin
        if (!rd_v && !sts.busy) begin
          state_next = gabr_pkg::ST_ALPHA_LO;
        end
      end
      gabr_pkg::ST_ALPHA_LO: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = gabr_pkg::OP_ALPHA_LO;
        state_next = gabr_pkg::ST_ALPHA_HI;
      end
      gabr_pkg::ST_ALPHA_HI: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = gabr_pkg::OP_ALPHA_HI;
        state_next = gabr_pkg::ST_BETA_C;
      end
      gabr_pkg::ST_BETA_C: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = gabr_pkg::OP_BETA_C;
        state_next = gabr_pkg::ST_SETTLE;
      end
      gabr_pkg::ST_SETTLE: begin
        if (!sts.busy) begin
          state_next = gabr_pkg::ST_EMIT;
        end
      end
      gabr_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (j == cfg_eff.p_last) begin
            state_next = gabr_pkg::ST_IDLE;
          end else begin
            j_next     = j + gabr_pkg::IDX_W'(1);
            state_next = gabr_pkg::ST_MAC;
          end
        end
      end
      default: begin
        state_next = gabr_pkg::ST_IDLE;
      end
    endcase
  end

  // result word register, parts the sequencer from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_row   <= row;
      out_col   <= j;
      out_value <= value;
      out_last  <= (j == cfg_eff.p_last);
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_gemm_alpha_beta_row_engine.sv =====
// tb_gemm_alpha_beta_row_engine: self-checking bench for the gemm row engine
// drives loads, row requests and register writes, predicts every result word in place
// depends on gabr_pkg, gabr_if and the gemm_alpha_beta_row_engine rtl
`timescale 1ns / 1ps

module tb_gemm_alpha_beta_row_engine;
  import gabr_pkg::*;

  localparam int RANDOM_ITEMS  = 420;
  localparam int SETTLE_CYCLES = DIM_LIMIT * (DIM_LIMIT + 8) + 64;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sh0001_0000;

  typedef struct packed {
    kind_t                   kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] val;
  } item_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } elem_due_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    kind_t                kind;
    logic [IDX_W-1:0]     row;
    logic [IDX_W-1:0]     col;
    logic [VAL_W-1:0]     val;
    logic                 lit;
    logic [VAL_W-1:0]     lit_val;
  } step_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PATTERN
  } rx_mode_t;

  localparam step_t DIRECTED [34] = '{
    '{1'b1, REG_ROWS_M,  KIND_LOAD_A, 4'd0,  4'd0,  32'h0000_0002, 1'b0, 32'h0},
    '{1'b1, REG_INNER_N, KIND_LOAD_A, 4'd0,  4'd0,  32'h0000_0001, 1'b0, 32'h0},
    '{1'b1, REG_COLS_P,  KIND_LOAD_A, 4'd0,  4'd0,  32'h0000_0001, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_A, 4'd0,  4'd0,  32'h0002_0000, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_B, 4'd0,  4'd0,  32'h0003_0000, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_C, 4'd0,  4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
    // alpha 1.0, beta 0 after reset: 2.0 * 3.0
    '{1'b0, REG_ROWS_M,  KIND_ROW,    4'd0,  4'd15, 32'hFFFF_FFFF, 1'b1, 32'h0006_0000},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_A, 4'd1,  4'd0,  32'h0000_0001, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_C, 4'd1,  4'd0,  32'h8000_0000, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_ROW,    4'd1,  4'd0,  32'h0000_0000, 1'b0, 32'h0},
    // rows beyond rows_m give no word
    '{1'b0, REG_ROWS_M,  KIND_ROW,    4'd2,  4'd9,  32'h1234_5678, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_ROW,    4'd15, 4'd15, 32'h8000_0000, 1'b0, 32'h0},
    '{1'b1, REG_SPARE,   KIND_LOAD_A, 4'd0,  4'd0,  32'hFFFF_FFFF, 1'b0, 32'h0},
    '{1'b1, REG_ALPHA,   KIND_LOAD_A, 4'd0,  4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{1'b1, REG_BETA,    KIND_LOAD_A, 4'd0,  4'd0,  32'h8000_0000, 1'b0, 32'h0},
    // zero dimensions act as one, upper data bits are dropped
    '{1'b1, REG_ROWS_M,  KIND_LOAD_A, 4'd0,  4'd0,  32'h0000_0020, 1'b0, 32'h0},
    '{1'b1, REG_INNER_N, KIND_LOAD_A, 4'd0,  4'd0,  32'hFFFF_FFE0, 1'b0, 32'h0},
    '{1'b1, REG_COLS_P,  KIND_LOAD_A, 4'd0,  4'd0,  32'h0000_0021, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_A, 4'd0,  4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_B, 4'd0,  4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_ROW,    4'd0,  4'd3,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_A, 4'd0,  4'd0,  32'h8000_0000, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_C, 4'd0,  4'd0,  32'h8000_0000, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_ROW,    4'd0,  4'd0,  32'h0000_0000, 1'b1, 32'h8000_0000},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_A, 4'd0,  4'd0,  32'h0000_0000, 1'b0, 32'h0},
    // only beta times c left, still past the top
    '{1'b0, REG_ROWS_M,  KIND_ROW,    4'd0,  4'd0,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
    '{1'b0, REG_ROWS_M,  KIND_ROW,    4'd1,  4'd0,  32'h0000_0000, 1'b0, 32'h0},
    '{1'b1, REG_ALPHA,   KIND_LOAD_A, 4'd0,  4'd0,  32'h0001_0000, 1'b0, 32'h0},
    '{1'b1, REG_BETA,    KIND_LOAD_A, 4'd0,  4'd0,  32'h0001_0000, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_A, 4'd0,  4'd0,  32'h0000_0001, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_B, 4'd0,  4'd0,  32'hFFFF_FFFF, 1'b0, 32'h0},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_C, 4'd0,  4'd0,  32'h0000_0000, 1'b0, 32'h0},
    // smallest negative product rounds down to minus one lsb
    '{1'b0, REG_ROWS_M,  KIND_ROW,    4'd0,  4'd0,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{1'b0, REG_ROWS_M,  KIND_LOAD_B, 4'd15, 4'd15, 32'h5A5A_A5A5, 1'b0, 32'h0}
  };

  logic clk;
  logic rst;

  gabr_in_if  item_ch ();
  gabr_out_if result_ch ();
  gabr_cfg_if cfg_ch ();

  gemm_alpha_beta_row_engine i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  logic signed [VAL_W-1:0] a_store [16][16];
  logic signed [VAL_W-1:0] b_store [16][16];
  logic signed [VAL_W-1:0] c_store [16][16];
  bit a_set [16][16];
  bit b_set [16][16];
  bit c_set [16][16];

  logic [DIM_W-1:0]        dim_m_q;
  logic [DIM_W-1:0]        dim_n_q;
  logic [DIM_W-1:0]        dim_p_q;
  logic signed [VAL_W-1:0] alpha_q;
  logic signed [VAL_W-1:0] beta_q;

  elem_due_t row_elems_due [$];
  int        fail_count = 0;
  int        burst_left = 0;

  rx_mode_t  rx_mode;
  int        rx_span = 0;
  logic [7:0] rx_pat;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int eff_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM_LIMIT) return DIM_LIMIT;
    return int'(d);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      4, 5, 6: return $urandom;
      7: return SAT_MAX;
      8: return SAT_MIN;
      default: return ($urandom_range(0, 1) != 0) ? ONE_Q16 : -32'sd1;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DIM_W'(16);
      2: return DIM_W'($urandom_range(17, 31));
      default: return DIM_W'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic item_word_t load_word(kind_t k, int r, int c);
    item_word_t w;
    w.kind = k;
    w.row = IDX_W'(r);
    w.col = IDX_W'(c);
    w.val = rand_elem();
    return w;
  endfunction

  // every store entry the row would read has been written
  function automatic bit row_ready(int r);
    int m, n, p, j, k;
    m = eff_dim(dim_m_q);
    n = eff_dim(dim_n_q);
    p = eff_dim(dim_p_q);
    if (r >= m) return 1'b1;
    for (k = 0; k < n; k++) begin
      if (!a_set[r][k]) return 1'b0;
      for (j = 0; j < p; j++) begin
        if (!b_set[k][j]) return 1'b0;
      end
    end
    for (j = 0; j < p; j++) begin
      if (!c_set[r][j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // alpha * floor(sum a*b >> 16) + beta * c, floored and saturated, one word per column
  task automatic predict_row(int r);
    int m, n, p, j, k;
    logic signed [127:0] acc;
    logic signed [127:0] tot;
    elem_due_t e;
    m = eff_dim(dim_m_q);
    n = eff_dim(dim_n_q);
    p = eff_dim(dim_p_q);
    if (r >= m) return;
    for (j = 0; j < p; j++) begin
      acc = '0;
      for (k = 0; k < n; k++) begin
        acc = acc + a_store[r][k] * b_store[k][j];
      end
      acc = acc >>> FRAC_W;
      tot = alpha_q * acc + beta_q * c_store[r][j];
      tot = tot >>> FRAC_W;
      e.row = IDX_W'(r);
      e.col = IDX_W'(j);
      if (tot > SAT_MAX) e.value = SAT_MAX;
      else if (tot < SAT_MIN) e.value = SAT_MIN;
      else e.value = tot[VAL_W-1:0];
      e.last = (j == p - 1);
      row_elems_due.push_back(e);
    end
  endtask

  task automatic report_miss(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    fail_count++;
    $display("%0t %s mismatch: expected %h, got %h", $time, field, want, got);
  endtask

  // entered and left at a falling edge
  task automatic send_word(item_word_t w, bit use_lit, logic [VAL_W-1:0] lit_val);
    elem_due_t e;
    if (burst_left == 0) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    item_ch.valid = 1'b1;
    item_ch.kind = w.kind;
    item_ch.row_index = w.row;
    item_ch.col_index = w.col;
    item_ch.elem_value = w.val;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    case (w.kind)
      KIND_LOAD_A: begin
        a_store[w.row][w.col] = w.val;
        a_set[w.row][w.col] = 1'b1;
      end
      KIND_LOAD_B: begin
        b_store[w.row][w.col] = w.val;
        b_set[w.row][w.col] = 1'b1;
      end
      KIND_LOAD_C: begin
        c_store[w.row][w.col] = w.val;
        c_set[w.row][w.col] = 1'b1;
      end
      default: begin
        if (use_lit) begin
          e.row = w.row;
          e.col = '0;
          e.value = lit_val;
          e.last = 1'b1;
          row_elems_due.push_back(e);
        end else begin
          predict_row(int'(w.row));
        end
      end
    endcase
    burst_left--;
    @(negedge clk);
  endtask

  // leaves cfg valid high; the caller drops it after the last write
  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_ROWS_M: dim_m_q = data[DIM_W-1:0];
      REG_INNER_N: dim_n_q = data[DIM_W-1:0];
      REG_COLS_P: dim_p_q = data[DIM_W-1:0];
      REG_ALPHA: alpha_q = data;
      REG_BETA: beta_q = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained(int settle);
    item_ch.valid = 1'b0;
    while (row_elems_due.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // loads for one row and up to two stray loads, shuffled, then one or two requests; returns the words that count
  task automatic run_sequence(output int sent);
    item_word_t loads [$];
    item_word_t t;
    item_word_t req;
    int r, r2, m, n, p, i, j, k, s;
    m = eff_dim(dim_m_q);
    n = eff_dim(dim_n_q);
    p = eff_dim(dim_p_q);
    sent = 0;
    r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, m - 1);
    if (r < m) begin
      for (k = 0; k < n; k++) begin
        if (!a_set[r][k] || $urandom_range(0, 3) == 0)
          loads.push_back(load_word(KIND_LOAD_A, r, k));
        for (j = 0; j < p; j++) begin
          if (!b_set[k][j] || $urandom_range(0, 5) == 0)
            loads.push_back(load_word(KIND_LOAD_B, k, j));
        end
      end
      for (j = 0; j < p; j++) begin
        if (!c_set[r][j] || $urandom_range(0, 3) == 0)
          loads.push_back(load_word(KIND_LOAD_C, r, j));
      end
    end
    repeat ($urandom_range(0, 2)) begin
      loads.push_back(load_word(kind_t'($urandom_range(0, 2)), $urandom_range(0, 15),
                                $urandom_range(0, 15)));
    end
    for (i = loads.size() - 1; i > 0; i--) begin
      s = $urandom_range(0, i);
      t = loads[i];
      loads[i] = loads[s];
      loads[s] = t;
    end
    foreach (loads[i]) begin
      send_word(loads[i], 1'b0, '0);
      sent++;
    end
    req.kind = KIND_ROW;
    req.row = IDX_W'(r);
    req.col = IDX_W'($urandom_range(0, 15));
    req.val = $urandom;
    send_word(req, 1'b0, '0);
    if (r < m) sent++;
    // ask again for a row whose data is already in place
    if ($urandom_range(0, 3) == 0) begin
      r2 = $urandom_range(0, 15);
      if (row_ready(r2)) begin
        req.row = IDX_W'(r2);
        req.col = IDX_W'($urandom_range(0, 15));
        req.val = $urandom;
        send_word(req, 1'b0, '0);
        if (r2 < m) sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(8, 80);
      rx_pat = 8'($urandom);
    end
    rx_span--;
    case (rx_mode)
      RX_FREE: result_ch.ready = 1'b1;
      RX_LIGHT: result_ch.ready = ($urandom_range(0, 3) != 0);
      RX_HEAVY: result_ch.ready = ($urandom_range(0, 3) == 0);
      default: begin
        result_ch.ready = rx_pat[0];
        rx_pat = {rx_pat[0], rx_pat[7:1]};
      end
    endcase
  end

  always @(posedge clk) begin : check_words
    elem_due_t due;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (row_elems_due.size() == 0) begin
        report_miss("unexpected word, out_value", 'x, result_ch.out_value);
      end else begin
        due = row_elems_due.pop_front();
        if (result_ch.out_row !== due.row)
          report_miss("out_row", VAL_W'(due.row), VAL_W'(result_ch.out_row));
        if (result_ch.out_col !== due.col)
          report_miss("out_col", VAL_W'(due.col), VAL_W'(result_ch.out_col));
        if (result_ch.out_value !== due.value)
          report_miss("out_value", due.value, result_ch.out_value);
        if (result_ch.last_of_row !== due.last)
          report_miss("last_of_row", VAL_W'(due.last), VAL_W'(result_ch.last_of_row));
      end
    end
  end

  initial begin : stimulus
    item_word_t w;
    bit prev_cfg;
    int sent, phase, phase_goal, phase_items, rand_items;
    logic [DIM_W-1:0] code_m, code_n, code_p;
    logic signed [VAL_W-1:0] alpha_pick, beta_pick;

    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.kind = KIND_LOAD_A;
    item_ch.row_index = '0;
    item_ch.col_index = '0;
    item_ch.elem_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ROWS_M;
    cfg_ch.data = '0;
    result_ch.ready = 1'b0;
    dim_m_q = RESET_DIM;
    dim_n_q = RESET_DIM;
    dim_p_q = RESET_DIM;
    alpha_q = RESET_ALPHA;
    beta_q = RESET_BETA;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    prev_cfg = 1'b0;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) begin
        if (!prev_cfg) wait_drained(SETTLE_CYCLES);
        program_reg(DIRECTED[i].reg_idx, DIRECTED[i].val);
      end else begin
        if (prev_cfg) cfg_ch.valid = 1'b0;
        w.kind = DIRECTED[i].kind;
        w.row = DIRECTED[i].row;
        w.col = DIRECTED[i].col;
        w.val = DIRECTED[i].val;
        send_word(w, DIRECTED[i].lit, DIRECTED[i].lit_val);
      end
      prev_cfg = DIRECTED[i].is_cfg;
    end

    rand_items = 0;
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      wait_drained(SETTLE_CYCLES);
      case (phase)
        0: begin
          code_m = DIM_W'(31);
          code_n = DIM_W'(16);
          code_p = DIM_W'(2);
          alpha_pick = SAT_MIN;
          beta_pick = SAT_MAX;
        end
        1: begin
          code_m = DIM_W'(16);
          code_n = DIM_W'(2);
          code_p = DIM_W'(17);
          alpha_pick = '0;
          beta_pick = ONE_Q16;
        end
        default: begin
          code_m = rand_dim();
          code_n = rand_dim();
          code_p = rand_dim();
          if (eff_dim(code_n) * eff_dim(code_p) > 40) code_p = DIM_W'($urandom_range(1, 3));
          alpha_pick = rand_elem();
          beta_pick = rand_elem();
        end
      endcase
      program_reg(REG_ROWS_M, ($urandom & 32'hFFFF_FFE0) | VAL_W'(code_m));
      program_reg(REG_INNER_N, ($urandom & 32'hFFFF_FFE0) | VAL_W'(code_n));
      program_reg(REG_COLS_P, ($urandom & 32'hFFFF_FFE0) | VAL_W'(code_p));
      program_reg(REG_ALPHA, alpha_pick);
      program_reg(REG_BETA, beta_pick);
      cfg_ch.valid = 1'b0;
      phase_goal = $urandom_range(40, 80);
      phase_items = 0;
      while (phase_items < phase_goal && rand_items + phase_items < RANDOM_ITEMS) begin
        run_sequence(sent);
        phase_items += sent;
        if ($urandom_range(0, 11) == 0) wait_drained(0);
      end
      rand_items += phase_items;
      phase++;
    end

    wait_drained(SETTLE_CYCLES);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
